/* rtl/core/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and sizes for the client session table.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int SLOTS  = 4;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int TIME_W = 32;
    localparam int TMO_W  = 8;
    localparam int LIM_W  = 3;
    localparam int CMD_W  = 2;
    localparam int OIDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_AUTH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd1;

    typedef enum logic [2:0] {
        SS_FREE    = 3'd0,
        SS_AUTH    = 3'd1,
        SS_OPEN    = 3'd2,
        SS_TIMEOUT = 3'd3,
        SS_FAILED  = 3'd4
    } slot_state_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_FULL        = 3'd1,
        STS_INVALID     = 3'd2,
        STS_NOT_AUTH    = 3'd3,
        STS_UNSUPPORTED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_ACTIVE_LIMIT    = 2'd0,
        REG_AUTH_TIMEOUT    = 2'd1,
        REG_IDLE_TIMEOUT    = 2'd2,
        REG_RECYCLE_TIMEOUT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_SWEEP = 2'd1,
        FSM_APPLY = 2'd2
    } fsm_state_t;

    typedef struct packed {
        logic load_req;
        logic sweep_step;
        logic apply;
    } dp_cmd_t;

    typedef struct packed {
        logic limit_zero;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/cst_ctrl.sv */
// ----------------------------------------------------------------------------
// cst_ctrl
// Request sequencer: accept, sweep the active slots, apply the transition.
// ----------------------------------------------------------------------------
module cst_ctrl
    import cst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.limit_zero ? FSM_APPLY : FSM_SWEEP;
                end
            end
            FSM_SWEEP: begin
                if (sts.sweep_last) begin
                    state_next = FSM_APPLY;
                end
            end
            FSM_APPLY: begin
                // wait for the output register to drain
                if (sts.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cmd.load_req   = 1'b0;
        cmd.sweep_step = 1'b0;
        cmd.apply      = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            FSM_SWEEP: begin
                cmd.sweep_step = 1'b1;
            end
            FSM_APPLY: begin
                cmd.apply = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != FSM_IDLE))
        else $error("accepted transfer did not start processing");

    a_apply_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |-> sts.out_free)
        else $error("apply issued while output register is occupied");

    a_sweep_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_SWEEP) |-> !sts.limit_zero)
        else $error("sweep running with zero active slots");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_req, cmd.sweep_step, cmd.apply}))
        else $error("more than one datapath command at once");
`endif

endmodule

/* rtl/core/cst_datapath.sv */
// ----------------------------------------------------------------------------
// cst_datapath
// Slot table, config registers, aging/match sweep and result register.
// ----------------------------------------------------------------------------
module cst_datapath
    import cst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        sts,
    input  logic [ADDR_W-1:0] in_addr,
    input  logic [PORT_W-1:0] in_port,
    input  logic [TIME_W-1:0] in_now,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic              in_ok,
    input  logic              in_self,
    input  logic              cfg_we,
    input  cfg_reg_t          cfg_sel,
    input  logic [TMO_W-1:0]  cfg_wdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output status_t           out_status,
    output logic [OIDX_W-1:0] out_slot,
    output slot_state_t       out_state
);

    // configuration
    logic [LIM_W-1:0] lim_reg;
    logic [TMO_W-1:0] auth_tmo_reg;
    logic [TMO_W-1:0] idle_tmo_reg;
    logic [TMO_W-1:0] recycle_tmo_reg;

    // slot table
    slot_state_t       state_reg [SLOTS];
    logic [ADDR_W-1:0] addr_reg  [SLOTS];
    logic [PORT_W-1:0] port_reg  [SLOTS];
    logic [TIME_W-1:0] last_reg  [SLOTS];

    // request
    logic [ADDR_W-1:0] req_addr_reg;
    logic [PORT_W-1:0] req_port_reg;
    logic [TIME_W-1:0] req_now_reg;
    logic [CMD_W-1:0]  req_cmd_reg;
    logic              req_ok_reg;
    logic              req_self_reg;

    // sweep
    logic [CNT_W-1:0] idx_reg;
    logic             emp_v_reg;
    logic [IDX_W-1:0] emp_idx_reg;
    logic             tgt_v_reg;
    logic [IDX_W-1:0] tgt_idx_reg;

    // result
    logic              m_valid_reg;
    status_t           res_status_reg;
    logic [OIDX_W-1:0] res_slot_reg;
    slot_state_t       res_state_reg;

    logic [CNT_W-1:0]  limit_eff;
    logic              use_target;
    logic              claim_v;
    logic [IDX_W-1:0]  claim_idx;
    logic [IDX_W-1:0]  slot_sel;
    logic              found;
    logic [IDX_W-1:0]  rd_idx;
    slot_state_t       st_cur;
    logic [TIME_W-1:0] elapsed;
    logic [TMO_W-1:0]  tmo;
    logic              expired;
    slot_state_t       aged;
    logic              active;
    logic              match;
    slot_state_t       st0;
    slot_state_t       st_new;
    status_t           status_new;

    assign limit_eff = (32'(lim_reg) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(lim_reg);

    // an auth request that matches restarts its slot as a claim
    assign use_target = tgt_v_reg && (req_cmd_reg != CMD_AUTH);
    assign claim_v    = !use_target && (tgt_v_reg || emp_v_reg);
    assign claim_idx  = tgt_v_reg ? tgt_idx_reg : emp_idx_reg;
    assign slot_sel   = use_target ? tgt_idx_reg : claim_idx;
    assign found      = use_target || claim_v;

    assign rd_idx  = cmd.sweep_step ? idx_reg[IDX_W-1:0] : slot_sel;
    assign st_cur  = state_reg[rd_idx];
    assign elapsed = req_now_reg - last_reg[rd_idx];

    always_comb begin
        case (st_cur)
            SS_AUTH: tmo = auth_tmo_reg;
            SS_OPEN: tmo = idle_tmo_reg;
            default: tmo = recycle_tmo_reg;
        endcase
    end

    assign expired = elapsed > TIME_W'(tmo);
    assign match   = (addr_reg[rd_idx] == req_addr_reg) && (port_reg[rd_idx] == req_port_reg);

    always_comb begin
        aged   = st_cur;
        active = 1'b1;
        if (st_cur == SS_FREE) begin
            active = 1'b0;
        end else if (expired) begin
            if (st_cur == SS_TIMEOUT) begin
                aged   = SS_FREE;
                active = 1'b0;
            end else begin
                aged = SS_TIMEOUT;
            end
        end
    end

    // transition for the chosen slot
    assign st0 = use_target ? st_cur : SS_FREE;

    always_comb begin
        st_new     = st0;
        status_new = STS_OK;
        if (!req_ok_reg) begin
            st_new     = SS_FAILED;
            status_new = STS_INVALID;
        end else if (req_cmd_reg != CMD_AUTH) begin
            if (st0 == SS_AUTH) begin
                st_new = SS_OPEN;
            end else if (st0 != SS_OPEN) begin
                st_new     = SS_FAILED;
                status_new = STS_NOT_AUTH;
            end
            if (status_new == STS_OK && req_cmd_reg != CMD_SERVICE) begin
                st_new     = SS_FAILED;
                status_new = STS_UNSUPPORTED;
            end
        end else if (!(req_self_reg && st0 == SS_FREE)) begin
            st_new     = SS_FAILED;
            status_new = STS_UNSUPPORTED;
        end else begin
            st_new = SS_AUTH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg         <= LIM_W'(4);
            auth_tmo_reg    <= TMO_W'(5);
            idle_tmo_reg    <= TMO_W'(120);
            recycle_tmo_reg <= TMO_W'(30);
        end else if (cfg_we) begin
            case (cfg_sel)
                REG_ACTIVE_LIMIT:    lim_reg         <= cfg_wdata[LIM_W-1:0];
                REG_AUTH_TIMEOUT:    auth_tmo_reg    <= cfg_wdata;
                REG_IDLE_TIMEOUT:    idle_tmo_reg    <= cfg_wdata;
                REG_RECYCLE_TIMEOUT: recycle_tmo_reg <= cfg_wdata;
                default:             lim_reg         <= lim_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                state_reg[i] <= SS_FREE;
            end
        end else if (cmd.sweep_step) begin
            state_reg[rd_idx] <= aged;
        end else if (cmd.apply && found) begin
            state_reg[rd_idx] <= st_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply && found) begin
            last_reg[rd_idx] <= req_now_reg;
            if (claim_v) begin
                addr_reg[rd_idx] <= req_addr_reg;
                port_reg[rd_idx] <= req_port_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_addr_reg <= in_addr;
            req_port_reg <= in_port;
            req_now_reg  <= in_now;
            req_cmd_reg  <= in_cmd;
            req_ok_reg   <= in_ok;
            req_self_reg <= in_self;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            emp_v_reg <= 1'b0;
            tgt_v_reg <= 1'b0;
        end else if (cmd.load_req) begin
            idx_reg   <= '0;
            emp_v_reg <= 1'b0;
            tgt_v_reg <= 1'b0;
        end else if (cmd.sweep_step) begin
            idx_reg <= idx_reg + CNT_W'(1);
            if (!active && !emp_v_reg) begin
                emp_v_reg <= 1'b1;
            end
            // highest matching index wins
            if (active && match) begin
                tgt_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep_step) begin
            if (!active && !emp_v_reg) begin
                emp_idx_reg <= rd_idx;
            end
            if (active && match) begin
                tgt_idx_reg <= rd_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            if (found) begin
                res_status_reg <= status_new;
                res_slot_reg   <= OIDX_W'(rd_idx);
                res_state_reg  <= st_new;
            end else begin
                res_status_reg <= STS_FULL;
                res_slot_reg   <= '0;
                res_state_reg  <= SS_FREE;
            end
        end
    end

    assign sts.limit_zero = (limit_eff == '0);
    assign sts.sweep_last = (idx_reg == limit_eff - CNT_W'(1));
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign out_status = res_status_reg;
    assign out_slot   = res_slot_reg;
    assign out_state  = res_state_reg;

`ifndef SYNTHESIS
    a_apply_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |=> m_valid_reg)
        else $error("apply did not produce a result");

    a_full_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_status_reg == STS_FULL) |->
            (res_slot_reg == '0 && res_state_reg == SS_FREE))
        else $error("slots-full result carries slot or state");

    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_step |-> (idx_reg < limit_eff))
        else $error("sweep index beyond active slot limit");
`endif

endmodule

/* rtl/core/client_session_table_unit.sv */
// ----------------------------------------------------------------------------
// client_session_table_unit
// Session slot table for control requests keyed by remote address and port.
// ----------------------------------------------------------------------------
// One request is processed at a time. After the input transfer, the unit
// sweeps min(active_slot_limit, SLOTS) slots, one per cycle through the
// table's single read/write port, aging each slot and looking for a match or
// a free slot; the apply state then applies the transition and loads the
// result register, waiting until the previous result transfers if the
// result register is still occupied. The next request is taken while the
// previous result still waits on the output. Config writes are always
// ready and must only be issued while no request is in flight.
module client_session_table_unit
    import cst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // remote_addr[31:0], udp_port[47:32], now_seconds[79:48]
    input  logic [3:0]  s_tuser,   // command[1:0], checks_ok[2], service_is_self[3]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // status[2:0], slot_index[4:3], slot_state_after[7:5]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    dp_cmd_t           cmd;
    dp_status_t        sts;
    status_t           out_status;
    logic [OIDX_W-1:0] out_slot;
    slot_state_t       out_state;

    assign cfg_ready = 1'b1;

    cst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cst_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_addr    (s_tdata[31:0]),
        .in_port    (s_tdata[47:32]),
        .in_now     (s_tdata[79:48]),
        .in_cmd     (s_tuser[1:0]),
        .in_ok      (s_tuser[2]),
        .in_self    (s_tuser[3]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_sel    (cfg_reg_t'(cfg_index)),
        .cfg_wdata  (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_slot   (out_slot),
        .out_state  (out_state)
    );

    assign m_tdata = {out_state, out_slot, out_status};

endmodule

/* tb/tb_client_session_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_client_session_table_unit
// Self-checking bench for the client session table unit.
// ----------------------------------------------------------------------------
// A directed plan walks the slot life cycle (claim, auth, open, fail, timeout,
// recycle, slots full, limit extremes), then random traffic from a small
// client pool drives request/service flows under three stall profiles.
// A local session predictor computes each result at the input transfer and
// every output transfer is compared against the oldest queued expectation.
// ----------------------------------------------------------------------------
module tb_client_session_table_unit
    import cst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_OTHER    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OTHER_HI = 2'd3;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 10;
    localparam int POOL          = 6;
    localparam int BLOCKS        = 8;
    localparam int BLOCK_ITEMS   = 60;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
        logic [CMD_W-1:0]  cmd;
        logic              ok;
        logic              own_svc;
    } request_t;

    typedef struct {
        status_t           status;
        logic [OIDX_W-1:0] slot;
        slot_state_t       state;
    } result_t;

    typedef struct {
        logic       is_cfg;
        cfg_reg_t   reg_idx;
        logic [7:0] value;
        request_t   rq;
        logic       typed;
        result_t    exp;
    } plan_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [3:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    // local copy of the block's registers and session table
    logic [LIM_W-1:0]  lim_reg;
    logic [TMO_W-1:0]  auth_tmo;
    logic [TMO_W-1:0]  idle_tmo;
    logic [TMO_W-1:0]  recycle_tmo;
    slot_state_t       tbl_state [SLOTS];
    logic [ADDR_W-1:0] tbl_addr  [SLOTS];
    logic [PORT_W-1:0] tbl_port  [SLOTS];
    logic [TIME_W-1:0] tbl_last  [SLOTS];
    logic [TIME_W-1:0] tbl_first [SLOTS];

    result_t           pending_results [$];
    plan_row_t         plan [$];
    logic [ADDR_W-1:0] client_addr [POOL];
    logic [PORT_W-1:0] client_port [POOL];
    logic [TIME_W-1:0] cur_now;
    int                src_idle_pct;
    int                sink_idle_pct;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    client_session_table_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Sweep, match/claim, then apply the transition; updates the local table.
    function automatic result_t resolve_request(request_t rq);
        int                lim;
        int                empty;
        int                target;
        int                slot;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] tmo;
        slot_state_t       st;
        status_t           sts;
        result_t           res;
        lim    = (lim_reg > SLOTS) ? SLOTS : int'(lim_reg);
        empty  = -1;
        target = -1;
        for (int i = 0; i < lim; i++) begin
            if (tbl_state[i] != SS_FREE) begin
                case (tbl_state[i])
                    SS_AUTH: tmo = TIME_W'(auth_tmo);
                    SS_OPEN: tmo = TIME_W'(idle_tmo);
                    default: tmo = TIME_W'(recycle_tmo);
                endcase
                elapsed = rq.now - tbl_last[i];
                if (elapsed > tmo) begin
                    tbl_state[i] = (tbl_state[i] == SS_TIMEOUT) ? SS_FREE : SS_TIMEOUT;
                end
            end
            if (tbl_state[i] == SS_FREE) begin
                if (empty < 0) empty = i;
            end else if (tbl_addr[i] == rq.addr && tbl_port[i] == rq.port) begin
                target = i;
            end
        end
        // an auth request restarts the slot it matched
        if (target >= 0 && rq.cmd == CMD_AUTH) begin
            empty  = target;
            target = -1;
        end
        if (target >= 0) begin
            slot = target;
            tbl_last[slot] = rq.now;
        end else if (empty >= 0) begin
            slot = empty;
            tbl_state[slot] = SS_FREE;
            tbl_first[slot] = rq.now;
            tbl_last[slot]  = rq.now;
            tbl_addr[slot]  = rq.addr;
            tbl_port[slot]  = rq.port;
        end else begin
            res.status = STS_FULL;
            res.slot   = '0;
            res.state  = SS_FREE;
            return res;
        end
        st  = tbl_state[slot];
        sts = STS_OK;
        if (!rq.ok) begin
            st  = SS_FAILED;
            sts = STS_INVALID;
        end else begin
            if (rq.cmd != CMD_AUTH) begin
                if (st == SS_AUTH) begin
                    st = SS_OPEN;
                end else if (st != SS_OPEN) begin
                    st  = SS_FAILED;
                    sts = STS_NOT_AUTH;
                end
            end
            if (sts == STS_OK) begin
                if (rq.cmd == CMD_AUTH && rq.own_svc && st == SS_FREE) begin
                    st = SS_AUTH;
                end else if (rq.cmd != CMD_SERVICE) begin
                    st  = SS_FAILED;
                    sts = STS_UNSUPPORTED;
                end
            end
        end
        tbl_state[slot] = st;
        res.status = sts;
        res.slot   = OIDX_W'(slot);
        res.state  = st;
        return res;
    endfunction

    function automatic plan_row_t req_row(logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p,
                                          logic [TIME_W-1:0] t, logic [CMD_W-1:0] c,
                                          logic ok, logic sv, logic typed, status_t es,
                                          logic [OIDX_W-1:0] ei, slot_state_t est);
        plan_row_t row;
        row.is_cfg     = 1'b0;
        row.reg_idx    = REG_ACTIVE_LIMIT;
        row.value      = '0;
        row.rq.addr    = a;
        row.rq.port    = p;
        row.rq.now     = t;
        row.rq.cmd     = c;
        row.rq.ok      = ok;
        row.rq.own_svc = sv;
        row.typed      = typed;
        row.exp.status = es;
        row.exp.slot   = ei;
        row.exp.state  = est;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(cfg_reg_t r, logic [7:0] v);
        plan_row_t row;
        row         = req_row('0, '0, '0, CMD_AUTH, 1'b0, 1'b0, 1'b0, STS_OK, '0, SS_FREE);
        row.is_cfg  = 1'b1;
        row.reg_idx = r;
        row.value   = v;
        return row;
    endfunction

    function automatic logic [TMO_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return TMO_W'($urandom_range(0, 255));
        return TMO_W'($urandom_range(1, 30));
    endfunction

    // Mostly well-formed flows from the client pool; a few noise requests.
    function automatic request_t make_request();
        request_t rq;
        int       r;
        int       c;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            rq.addr    = $urandom();
            rq.port    = PORT_W'($urandom());
            rq.now     = $urandom_range(0, 1) ? $urandom() : cur_now;
            rq.cmd     = CMD_W'($urandom_range(0, 3));
            rq.ok      = 1'($urandom_range(0, 1));
            rq.own_svc = 1'($urandom_range(0, 1));
            return rq;
        end
        c = $urandom_range(0, POOL - 1);
        r = $urandom_range(0, 99);
        if (r < 70) cur_now = cur_now + $urandom_range(0, 3);
        else if (r < 92) cur_now = cur_now + $urandom_range(4, 40);
        else cur_now = cur_now + $urandom_range(41, 400);
        rq.addr = client_addr[c];
        rq.port = client_port[c];
        rq.now  = cur_now;
        r = $urandom_range(0, 99);
        if (r < 30) rq.cmd = CMD_AUTH;
        else if (r < 85) rq.cmd = CMD_SERVICE;
        else rq.cmd = $urandom_range(0, 1) ? CMD_OTHER : CMD_OTHER_HI;
        rq.ok      = ($urandom_range(0, 99) >= 6);
        rq.own_svc = ($urandom_range(0, 99) >= 8);
        return rq;
    endfunction

    task automatic flag_error(string msg);
        mismatches++;
        if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic send_request(request_t rq, logic typed, result_t typed_exp);
        result_t pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rq.now, rq.port, rq.addr};
        s_tuser  <= {rq.own_svc, rq.ok, rq.cmd};
        do @(posedge aclk); while (!s_tready);
        pred = resolve_request(rq);
        pending_results.push_back(typed ? typed_exp : pred);
    endtask

    task automatic write_cfg(cfg_reg_t r, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (r)
            REG_ACTIVE_LIMIT: lim_reg     = v[LIM_W-1:0];
            REG_AUTH_TIMEOUT: auth_tmo    = v;
            REG_IDLE_TIMEOUT: idle_tmo    = v;
            default:          recycle_tmo = v;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid, let every predicted result drain, then let the unit settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: check each transfer, then pick next-cycle ready
    initial begin
        result_t exp;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_tvalid && m_tready) begin
                    if (pending_results.size() == 0) begin
                        flag_error($sformatf("unexpected result 0x%02h", m_tdata));
                    end else begin
                        exp = pending_results.pop_front();
                        if (m_tdata[2:0] !== exp.status)
                            flag_error($sformatf("status got %0d exp %0d",
                                                 m_tdata[2:0], exp.status));
                        if (m_tdata[4:3] !== exp.slot)
                            flag_error($sformatf("slot_index got %0d exp %0d",
                                                 m_tdata[4:3], exp.slot));
                        if (m_tdata[7:5] !== exp.state)
                            flag_error($sformatf("slot_state_after got %0d exp %0d",
                                                 m_tdata[7:5], exp.state));
                    end
                end
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        result_t none;
        int      lim;
        int      k;
        none.status   = STS_OK;
        none.slot     = '0;
        none.state    = SS_FREE;
        src_idle_pct  = 36;
        sink_idle_pct = 81;
        lim_reg       = 3'd4;
        auth_tmo      = 8'd5;
        idle_tmo      = 8'd120;
        recycle_tmo   = 8'd30;
        cur_now       = 32'd1000;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_state[i] = SS_FREE;
            tbl_addr[i]  = '0;
            tbl_port[i]  = '0;
            tbl_last[i]  = '0;
            tbl_first[i] = '0;
        end
        for (int i = 0; i < POOL; i++) begin
            client_addr[i] = $urandom();
            client_port[i] = PORT_W'($urandom());
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // life of a slot from reset: claim, open, other code, reuse, timeouts
        plan.push_back(req_row(32'h0, 16'h0, 32'd0, CMD_AUTH, 1, 1, 1,
                               STS_OK, 2'd0, SS_AUTH));
        plan.push_back(req_row(32'h0, 16'h0, 32'd5, CMD_SERVICE, 1, 0, 1,
                               STS_OK, 2'd0, SS_OPEN));
        plan.push_back(req_row(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, CMD_OTHER_HI, 1, 1, 1,
                               STS_NOT_AUTH, 2'd1, SS_FAILED));
        // time wraps; matched auth with bad checks restarts its slot
        plan.push_back(req_row(32'hFFFF_FFFF, 16'hFFFF, 32'd0, CMD_AUTH, 0, 1, 1,
                               STS_INVALID, 2'd1, SS_FAILED));
        plan.push_back(req_row(32'h1234_5678, 16'h0001, 32'd1, CMD_SERVICE, 1, 1, 1,
                               STS_NOT_AUTH, 2'd0, SS_FAILED));
        plan.push_back(req_row(32'hC0A8_0001, 16'd5000, 32'd2, CMD_AUTH, 1, 0, 1,
                               STS_UNSUPPORTED, 2'd2, SS_FAILED));
        plan.push_back(req_row(32'h0A00_0001, 16'd80, 32'd3, CMD_AUTH, 1, 1, 1,
                               STS_OK, 2'd3, SS_AUTH));
        plan.push_back(req_row(32'h0A00_0002, 16'd81, 32'd3, CMD_AUTH, 1, 1, 1,
                               STS_FULL, 2'd0, SS_FREE));
        plan.push_back(req_row(32'h0A00_0001, 16'd80, 32'd8, CMD_SERVICE, 1, 1, 1,
                               STS_OK, 2'd3, SS_OPEN));
        plan.push_back(req_row(32'h0A00_0001, 16'd80, 32'd9, CMD_OTHER, 1, 1, 1,
                               STS_UNSUPPORTED, 2'd3, SS_FAILED));
        plan.push_back(req_row(32'h0A00_0001, 16'd80, 32'd10, CMD_AUTH, 1, 1, 1,
                               STS_OK, 2'd3, SS_AUTH));
        plan.push_back(req_row(32'h0A00_0001, 16'd80, 32'd16, CMD_SERVICE, 1, 1, 1,
                               STS_NOT_AUTH, 2'd3, SS_FAILED));
        plan.push_back(req_row(32'h0A00_0003, 16'd9, 32'd100, CMD_AUTH, 1, 1, 1,
                               STS_FULL, 2'd0, SS_FREE));
        plan.push_back(req_row(32'h0A00_0003, 16'd9, 32'd131, CMD_AUTH, 1, 1, 1,
                               STS_OK, 2'd0, SS_AUTH));
        // zero limit, then a limit above the slot count
        plan.push_back(cfg_row(REG_ACTIVE_LIMIT, 8'd0));
        plan.push_back(req_row(32'h0A00_0004, 16'd7, 32'd200, CMD_AUTH, 1, 1, 1,
                               STS_FULL, 2'd0, SS_FREE));
        plan.push_back(cfg_row(REG_ACTIVE_LIMIT, 8'd7));
        plan.push_back(cfg_row(REG_AUTH_TIMEOUT, 8'd0));
        plan.push_back(req_row(32'h0A00_0003, 16'd9, 32'd131, CMD_SERVICE, 1, 1, 1,
                               STS_OK, 2'd0, SS_OPEN));
        plan.push_back(cfg_row(REG_IDLE_TIMEOUT, 8'd0));
        plan.push_back(req_row(32'h0A00_0003, 16'd9, 32'd132, CMD_SERVICE, 1, 1, 0,
                               STS_OK, 2'd0, SS_FREE));
        plan.push_back(cfg_row(REG_RECYCLE_TIMEOUT, 8'd0));
        plan.push_back(req_row(32'h0A00_0003, 16'd9, 32'd133, CMD_SERVICE, 1, 1, 0,
                               STS_OK, 2'd0, SS_FREE));
        plan.push_back(cfg_row(REG_RECYCLE_TIMEOUT, 8'd255));
        plan.push_back(req_row(32'h0A00_0003, 16'd9, 32'd400, CMD_AUTH, 1, 1, 0,
                               STS_OK, 2'd0, SS_FREE));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_idle();
                write_cfg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_request(plan[i].rq, plan[i].typed, plan[i].exp);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 36;
                    sink_idle_pct = 81;
                end
                1: begin
                    src_idle_pct  = 81;
                    sink_idle_pct = 36;
                    cur_now       = $urandom();
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    cur_now       = 32'hFFFF_FF80;
                end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++) begin
                wait_idle();
                if (blk == 0 || $urandom_range(0, 1)) begin
                    k   = $urandom_range(0, 9);
                    lim = (k == 0) ? 0 : (k == 1) ? $urandom_range(5, 7) :
                          (k < 4) ? $urandom_range(1, 3) : 4;
                    write_cfg(REG_ACTIVE_LIMIT, 8'(lim));
                end
                if (blk == 0 || $urandom_range(0, 1)) write_cfg(REG_AUTH_TIMEOUT, pick_timeout());
                if (blk == 0 || $urandom_range(0, 1)) write_cfg(REG_IDLE_TIMEOUT, pick_timeout());
                if (blk == 0 || $urandom_range(0, 1))
                    write_cfg(REG_RECYCLE_TIMEOUT, pick_timeout());
                // new clients; sometimes two share an address on different ports
                k = $urandom_range(0, POOL - 1);
                client_addr[k] = $urandom();
                client_port[k] = PORT_W'($urandom());
                if ($urandom_range(0, 1)) begin
                    client_addr[POOL-1] = client_addr[0];
                    client_port[POOL-1] = client_port[0] ^ PORT_W'($urandom_range(1, 65535));
                end
                repeat (BLOCK_ITEMS) send_request(make_request(), 1'b0, none);
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
